// ===== rtl/xhf_pkg.sv =====
// shared types, constants and lookup functions for the hex frame decoder
package xhf_pkg;

    localparam int LINE_MAX_DEF   = 128;
    localparam int KEY_LENGTH_DEF = 15;
    localparam int QUEUE_DEPTH    = 4;
    localparam int PREFIX_LEN     = 4;
    localparam int MIN_CONTENT    = 8;
    localparam int TDATA_W        = 16;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PREFIX   = 3'd1,
        ST_SEP      = 3'd2,
        ST_CSUM_HEX = 3'd3,
        ST_ODD      = 3'd4,
        ST_PAY_HEX  = 3'd5,
        ST_MISMATCH = 3'd6
    } status_t;

    // one queued request: an optional plaintext byte, then an optional line status
    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       has_status;
        status_t    status;
    } entry_t;

    function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h53;
            2'd1:    b = 8'h45;
            2'd2:    b = 8'h43;
            default: b = 8'h3A;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] key_byte(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h43;
            6'd1:    b = 8'h47;
            6'd2:    b = 8'h32;
            6'd3:    b = 8'h32;
            6'd4:    b = 8'h37;
            6'd5:    b = 8'h31;
            6'd6:    b = 8'h5F;
            6'd7:    b = 8'h55;
            6'd8:    b = 8'h41;
            6'd9:    b = 8'h52;
            6'd10:   b = 8'h54;
            6'd11:   b = 8'h5F;
            6'd12:   b = 8'h4B;
            6'd13:   b = 8'h45;
            6'd14:   b = 8'h59;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // bit 4 set when the character is a hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: r = {1'b1, 4'(c[3:0] + 4'd9)};
            default:       r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/xhf_front.sv =====
// front end: per-byte line parser, emits queue requests for bytes and line status
module xhf_front
    import xhf_pkg::*;
#(
    parameter int LINE_MAX   = LINE_MAX_DEF,
    parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       queue_full,
    output logic       in_ready,
    output logic       push,
    output entry_t     push_entry
);

    localparam int LW = $clog2(LINE_MAX);
    localparam int KW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

    logic [LW-1:0] line_len_reg,  line_len_next;
    logic [LW-1:0] content_reg,   content_next;
    logic [LW-1:0] colon_idx_reg, colon_idx_next;
    logic          cr_reg,        cr_next;
    logic          prefix_ok_reg, prefix_ok_next;
    logic          colon_reg,     colon_next;
    logic [9:0]    csum_reg,      csum_next;
    logic [1:0]    tail_reg,      tail_next;
    logic          pay_bad_reg,   pay_bad_next;
    logic          seg_bad_reg,   seg_bad_next;
    logic [7:0]    xor_reg,       xor_next;
    logic [4:0]    nib_reg,       nib_next;
    logic [KW-1:0] kpos_reg,      kpos_next;

    logic accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        logic [4:0]  hv;
        logic [7:0]  cipher;
        logic [KW:0] kpos_inc;
        logic        line_end;
        status_t     st;

        line_len_next  = line_len_reg;
        content_next   = content_reg;
        colon_idx_next = colon_idx_reg;
        cr_next        = cr_reg;
        prefix_ok_next = prefix_ok_reg;
        colon_next     = colon_reg;
        csum_next      = csum_reg;
        tail_next      = tail_reg;
        pay_bad_next   = pay_bad_reg;
        seg_bad_next   = seg_bad_reg;
        xor_next       = xor_reg;
        nib_next       = nib_reg;
        kpos_next      = kpos_reg;
        push           = 1'b0;
        push_entry     = '0;
        hv             = hex_decode(in_byte);
        cipher         = {nib_reg[3:0], hv[3:0]};
        kpos_inc       = {1'b0, kpos_reg} + 1'b1;
        line_end       = 1'b0;
        st             = ST_OK;

        if (accept) begin
            if (in_byte != CH_NEWLINE && !cr_reg) begin
                if (in_byte == CH_CR || in_byte == CH_NUL) begin
                    cr_next = 1'b1;
                end else begin
                    if (content_reg < LW'(PREFIX_LEN)) begin
                        if (in_byte != prefix_byte(content_reg[1:0])) begin
                            prefix_ok_next = 1'b0;
                        end
                    end else if (in_byte == CH_COLON) begin
                        if (seg_bad_reg || colon_reg) begin
                            pay_bad_next = 1'b1;
                        end
                        colon_next     = 1'b1;
                        colon_idx_next = content_reg;
                        seg_bad_next   = 1'b0;
                        tail_next      = 2'd0;
                        csum_next      = '0;
                    end else begin
                        if (!hv[4]) begin
                            seg_bad_next = 1'b1;
                        end
                        if (colon_reg) begin
                            // checksum tail: keep the first two digits only
                            if (hv[4] && tail_reg == 2'd0) begin
                                csum_next[8]   = 1'b1;
                                csum_next[3:0] = hv[3:0];
                            end else if (hv[4] && tail_reg == 2'd1) begin
                                csum_next[9]   = 1'b1;
                                csum_next[7:4] = hv[3:0];
                            end
                            if (tail_reg != 2'd3) begin
                                tail_next = tail_reg + 2'd1;
                            end
                        end else if (prefix_ok_reg && hv[4] && !seg_bad_reg) begin
                            if (!nib_reg[4]) begin
                                nib_next = {1'b1, hv[3:0]};
                            end else begin
                                nib_next        = '0;
                                xor_next        = xor_reg ^ cipher;
                                push            = 1'b1;
                                push_entry.has_data = 1'b1;
                                push_entry.data = cipher ^ key_byte(6'(kpos_reg));
                                kpos_next = (kpos_inc >= (KW+1)'(KEY_LENGTH)) ? '0
                                                                              : kpos_inc[KW-1:0];
                            end
                        end
                    end
                    content_next = content_reg + 1'b1;
                end
            end

            line_len_next = line_len_reg + 1'b1;
            line_end = (in_byte == CH_NEWLINE) || (line_len_next >= LW'(LINE_MAX - 1));

            if (!prefix_ok_next || content_next < LW'(MIN_CONTENT)) begin
                st = ST_PREFIX;
            end else if (!colon_next || colon_idx_next <= LW'(PREFIX_LEN)
                         || tail_next < 2'd2) begin
                st = ST_SEP;
            end else if (csum_next[9:8] != 2'b11) begin
                st = ST_CSUM_HEX;
            end else if (colon_idx_next[0]) begin
                st = ST_ODD;
            end else if (pay_bad_next) begin
                st = ST_PAY_HEX;
            end else if (xor_next != {csum_next[3:0], csum_next[7:4]}) begin
                st = ST_MISMATCH;
            end

            if (line_end) begin
                push                  = 1'b1;
                push_entry.has_status = 1'b1;
                push_entry.status     = st;
                line_len_next  = '0;
                content_next   = '0;
                colon_idx_next = '0;
                cr_next        = 1'b0;
                prefix_ok_next = 1'b1;
                colon_next     = 1'b0;
                csum_next      = '0;
                tail_next      = '0;
                pay_bad_next   = 1'b0;
                seg_bad_next   = 1'b0;
                xor_next       = '0;
                nib_next       = '0;
                kpos_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg  <= '0;
            content_reg   <= '0;
            colon_idx_reg <= '0;
            cr_reg        <= 1'b0;
            prefix_ok_reg <= 1'b1;
            colon_reg     <= 1'b0;
            csum_reg      <= '0;
            tail_reg      <= '0;
            pay_bad_reg   <= 1'b0;
            seg_bad_reg   <= 1'b0;
            xor_reg       <= '0;
            nib_reg       <= '0;
            kpos_reg      <= '0;
        end else begin
            line_len_reg  <= line_len_next;
            content_reg   <= content_next;
            colon_idx_reg <= colon_idx_next;
            cr_reg        <= cr_next;
            prefix_ok_reg <= prefix_ok_next;
            colon_reg     <= colon_next;
            csum_reg      <= csum_next;
            tail_reg      <= tail_next;
            pay_bad_reg   <= pay_bad_next;
            seg_bad_reg   <= seg_bad_next;
            xor_reg       <= xor_next;
            nib_reg       <= nib_next;
            kpos_reg      <= kpos_next;
        end
    end

endmodule

// ===== rtl/xhf_queue.sv =====
// short request queue between the parser and the output stage
module xhf_queue
    import xhf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head_entry,
    output logic   empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    entry_t        mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg,  count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/xhf_back.sv =====
// back end: holds one request and plays out its byte and status results
module xhf_back
    import xhf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  entry_t             head_entry,
    input  logic               empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    entry_t hold_reg, hold_next;
    logic   busy, out_take, last_left;

    assign busy      = hold_reg.has_data || hold_reg.has_status;
    assign out_take  = m_tvalid && m_tready;
    assign last_left = !(hold_reg.has_data && hold_reg.has_status);
    assign pop       = !empty && (!busy || (out_take && last_left));

    assign m_tvalid = busy;
    assign m_tlast  = !hold_reg.has_data && hold_reg.has_status;
    // data byte goes out first, status after it
    assign m_tdata  = hold_reg.has_data
                    ? {{(TDATA_W-8){1'b0}}, hold_reg.data}
                    : {{(TDATA_W-11){1'b0}}, hold_reg.status, 8'h00};

    always_comb begin
        hold_next = hold_reg;
        if (out_take) begin
            if (hold_reg.has_data) begin
                hold_next.has_data = 1'b0;
            end else begin
                hold_next.has_status = 1'b0;
            end
        end
        if (pop) begin
            hold_next = head_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg.has_data   <= 1'b0;
            hold_reg.has_status <= 1'b0;
        end else begin
            hold_reg.has_data   <= hold_next.has_data;
            hold_reg.has_status <= hold_next.has_status;
        end
        hold_reg.data   <= hold_next.data;
        hold_reg.status <= hold_next.status;
    end

endmodule

// ===== rtl/xor_hex_frame_decoder.sv =====
// Receives one character per accepted request on the s_ stream and decodes
// lines of the form SEC:<hex pairs>:<two hex checksum digits>. Each complete
// payload pair comes out at once on the m_ stream as one byte XORed with a
// repeating key; at each newline, or after LINE_MAX-1 bytes, a status result
// follows with tlast high. A new byte is taken every cycle while the four-entry
// request queue has room; the output stage plays out one result per cycle while
// m_tready is high, so a byte that both completes a pair and ends the line gives
// two results from one request, and the queue absorbs it. Byte results are
// tentative and are to be used only when the line's status is zero.
module xor_hex_frame_decoder
    import xhf_pkg::*;
#(
    parameter int LINE_MAX   = LINE_MAX_DEF,
    parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] plain_byte, [10:8] status_code
    output logic               m_tlast    // is_status
);

    logic   push, queue_full, pop, queue_empty;
    entry_t push_entry, head_entry;

    xhf_front #(
        .LINE_MAX   (LINE_MAX),
        .KEY_LENGTH (KEY_LENGTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    xhf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (queue_empty)
    );

    xhf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .empty      (queue_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/xhf_checker.sv =====
// port-level checks on the decoder's output stream, bound to the top level
module xhf_checker
    import xhf_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a status result carries no byte and a code below 7
    a_status_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00 && m_tdata[10:8] != 3'd7)
        else $error("status result with byte or bad code");

    // a byte result carries status zero and clean padding
    a_byte_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[TDATA_W-1:8] == '0)
        else $error("byte result with status bits set");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind xor_hex_frame_decoder xhf_checker u_xhf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/xor_hex_frame_decoder_tb.sv =====
// self-checking testbench for the keyed-xor hex frame decoder
module xor_hex_frame_decoder_tb
    import xhf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        FL_NONE,
        FL_PREFIX,
        FL_SHORT,
        FL_NO_SEP,
        FL_CSUM_SHORT,
        FL_CSUM_NONHEX,
        FL_ODD,
        FL_PAY_NONHEX,
        FL_EXTRA_COLON,
        FL_MISMATCH,
        FL_TRAILING,
        FL_CR,
        FL_NUL,
        FL_NOISE
    } line_flaw_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] plain;
        status_t    code;
    } decoded_t;

    localparam logic [7:0] KEY_TABLE [KEY_LENGTH_DEF] = '{
        8'h43, 8'h47, 8'h32, 8'h32, 8'h37, 8'h31, 8'h5F, 8'h55,
        8'h41, 8'h52, 8'h54, 8'h5F, 8'h4B, 8'h45, 8'h59
    };
    localparam logic [7:0] FRAME_HEAD [PREFIX_LEN] = '{8'h53, 8'h45, 8'h43, 8'h3A};
    localparam int RANDOM_BYTES = 170;
    localparam int LONG_HOLD    = 80;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;

    xor_hex_frame_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    logic [7:0] rx_bytes [$];
    decoded_t   decoded_due [$];

    // line decoder mirror
    int         ln_len;
    bit         ln_term;
    int         content_cnt;
    bit         pfx_ok;
    int         colon_idx;
    bit         colon_seen;
    logic [9:0] csum_hold;
    int         tail_cnt;
    bit         pay_bad;
    bit         seg_bad;
    logic [7:0] xor_acc;
    logic [4:0] nib_hold;
    int         key_idx;

    bit s_took      = 1'b0;
    int bytes_taken = 0;
    int lines_built = 0;
    int data_seen   = 0;
    int status_seen [7];
    int mismatches  = 0;
    int tx_gap = 0, tx_calm = 0;
    int rx_gap = 0, rx_calm = 0, rx_hold = 0;
    bit hold_done = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    task automatic clear_line();
        ln_len      = 0;
        ln_term     = 1'b0;
        content_cnt = 0;
        pfx_ok      = 1'b1;
        colon_idx   = 0;
        colon_seen  = 1'b0;
        csum_hold   = '0;
        tail_cnt    = 0;
        pay_bad     = 1'b0;
        seg_bad     = 1'b0;
        xor_acc     = '0;
        nib_hold    = '0;
        key_idx     = 0;
    endtask

    function automatic status_t line_verdict();
        if (!pfx_ok || content_cnt < MIN_CONTENT) return ST_PREFIX;
        if (!colon_seen || colon_idx <= PREFIX_LEN || tail_cnt < 2) return ST_SEP;
        if (csum_hold[9:8] != 2'b11) return ST_CSUM_HEX;
        if (colon_idx % 2 != 0) return ST_ODD;
        if (pay_bad) return ST_PAY_HEX;
        if (xor_acc != {csum_hold[3:0], csum_hold[7:4]}) return ST_MISMATCH;
        return ST_OK;
    endfunction

    task automatic parse_char(input logic [7:0] c);
        int         hv;
        logic [7:0] cipher;
        if (content_cnt < PREFIX_LEN) begin
            if (c != FRAME_HEAD[content_cnt]) pfx_ok = 1'b0;
            return;
        end
        if (c == CH_COLON) begin
            if (seg_bad || colon_seen) pay_bad = 1'b1;
            colon_seen = 1'b1;
            colon_idx  = content_cnt;
            seg_bad    = 1'b0;
            tail_cnt   = 0;
            csum_hold  = '0;
            return;
        end
        hv = digit_value(c);
        if (hv < 0) seg_bad = 1'b1;
        if (colon_seen) begin
            if (hv >= 0) begin
                if (tail_cnt == 0) begin
                    csum_hold[8]   = 1'b1;
                    csum_hold[3:0] = hv[3:0];
                end else if (tail_cnt == 1) begin
                    csum_hold[9]   = 1'b1;
                    csum_hold[7:4] = hv[3:0];
                end
            end
            if (tail_cnt < 3) tail_cnt++;
            return;
        end
        if (!pfx_ok || seg_bad) return;
        if (!nib_hold[4]) begin
            nib_hold = {1'b1, hv[3:0]};
        end else begin
            cipher   = {nib_hold[3:0], hv[3:0]};
            nib_hold = '0;
            xor_acc  = xor_acc ^ cipher;
            decoded_due.push_back('{1'b0, cipher ^ KEY_TABLE[key_idx], ST_OK});
            key_idx  = (key_idx + 1 >= KEY_LENGTH_DEF) ? 0 : key_idx + 1;
        end
    endtask

    task automatic decode_rx_byte(input logic [7:0] c);
        bit nl;
        nl = (c == CH_NEWLINE);
        if (!nl && !ln_term) begin
            if (c == CH_CR || c == CH_NUL) begin
                ln_term = 1'b1;
            end else begin
                parse_char(c);
                content_cnt++;
            end
        end
        ln_len++;
        if (nl || ln_len >= LINE_MAX_DEF - 1) begin
            decoded_due.push_back('{1'b1, 8'h00, line_verdict()});
            clear_line();
        end
    endtask

    task automatic check_result(input logic last, input logic [TDATA_W-1:0] data);
        decoded_t want;
        if (decoded_due.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: result with nothing pending: tlast=%0b tdata=%h",
                         $realtime, last, data);
            mismatches++;
            return;
        end
        want = decoded_due.pop_front();
        if (want.is_status) status_seen[want.code]++;
        else data_seen++;
        if (last !== want.is_status || data[7:0] !== want.plain
                || data[10:8] !== want.code || data[TDATA_W-1:11] !== '0) begin
            if (mismatches < 10)
                $display("%0t: mismatch: expected last=%0b plain=%h status=%0d,",
                         $realtime, want.is_status, want.plain, want.code,
                         " got last=%0b plain=%h status=%0d pad=%h",
                         last, data[7:0], data[10:8], data[TDATA_W-1:11]);
            mismatches++;
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
        if (v < 4'd10) return 8'h30 + {4'd0, v};
        return base + {4'd0, v} - 8'd10;
    endfunction

    // any character that is not hex, colon or a line control
    function automatic logic [7:0] pick_junk();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (digit_value(c) >= 0 || c == CH_COLON || c == CH_NEWLINE || c == CH_CR);
        return c;
    endfunction

    task automatic queue_line(input line_flaw_t flaw, input int pairs);
        logic [7:0] ln [$];
        logic [7:0] csum;
        logic [7:0] b;
        int         pos;
        csum = '0;
        if (flaw == FL_NOISE) begin
            repeat ($urandom_range(1, 24)) ln.push_back(8'($urandom));
            if ($urandom_range(0, 1)) ln.push_back(CH_NEWLINE);
        end else begin
            foreach (FRAME_HEAD[i]) ln.push_back(FRAME_HEAD[i]);
            if (flaw == FL_PREFIX) begin
                pos = $urandom_range(0, PREFIX_LEN - 1);
                do b = pick_junk(); while (b == ln[pos]);
                ln[pos] = b;
            end
            if (flaw == FL_SHORT) begin
                repeat ($urandom_range(0, 3)) ln.push_back(hex_char(4'($urandom)));
            end else begin
                for (int k = 0; k < pairs; k++) begin
                    b = 8'($urandom);
                    csum ^= b;
                    ln.push_back(hex_char(b[7:4]));
                    ln.push_back(hex_char(b[3:0]));
                end
                if (flaw == FL_ODD) ln.push_back(hex_char(4'($urandom)));
                if (flaw == FL_PAY_NONHEX) begin
                    if (pairs > 0) ln[PREFIX_LEN + $urandom_range(0, 2 * pairs - 1)] = pick_junk();
                    else ln.push_back(pick_junk());
                end
                if (flaw == FL_EXTRA_COLON)
                    ln.insert(PREFIX_LEN + 2 * $urandom_range(0, pairs), CH_COLON);
                if (flaw != FL_NO_SEP) begin
                    ln.push_back(CH_COLON);
                    if (flaw == FL_MISMATCH) csum ^= 8'($urandom_range(1, 255));
                    ln.push_back(hex_char(csum[7:4]));
                    if (flaw != FL_CSUM_SHORT) ln.push_back(hex_char(csum[3:0]));
                    if (flaw == FL_CSUM_NONHEX)
                        ln[ln.size() - 1 - $urandom_range(0, 1)] = pick_junk();
                end
                if (flaw == FL_TRAILING) begin
                    repeat ($urandom_range(1, 4)) begin
                        do b = 8'($urandom); while (b == CH_NEWLINE || b == CH_CR || b == CH_NUL);
                        ln.push_back(b);
                    end
                end
                if (flaw == FL_CR || flaw == FL_NUL) begin
                    ln.push_back(flaw == FL_CR ? CH_CR : CH_NUL);
                    repeat ($urandom_range(0, 5)) begin
                        do b = 8'($urandom); while (b == CH_NEWLINE);
                        ln.push_back(b);
                    end
                end
            end
            ln.push_back(CH_NEWLINE);
        end
        foreach (ln[i]) rx_bytes.push_back(ln[i]);
        lines_built++;
    endtask

    // request sampling, prediction and checking
    always @(posedge aclk) begin
        s_took = 1'b0;
        if (aresetn) begin
            s_took = s_tvalid && s_tready;
            if (s_took) begin
                decode_rx_byte(s_tdata);
                bytes_taken++;
            end
            if (m_tvalid && m_tready) check_result(m_tlast, m_tdata);
        end
    end

    // sender: holds a request until it is taken, gaps skipped while the receiver is held off
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (tx_gap > 0 && rx_hold == 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (rx_bytes.size() != 0) begin
                s_tdata  <= rx_bytes.pop_front();
                s_tvalid <= 1'b1;
                if (tx_calm > 0) begin
                    tx_calm <= tx_calm - 1;
                    tx_gap  <= 0;
                end else begin
                    tx_gap <= draw_gap();
                    if ($urandom_range(0, 59) == 0) tx_calm <= $urandom_range(30, 60);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (!hold_done && bytes_taken >= 300) begin
            m_tready  <= 1'b0;
            rx_hold   <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (rx_calm > 0) begin
                rx_calm <= rx_calm - 1;
            end else begin
                if ($urandom_range(0, 2) == 0) rx_gap <= draw_gap();
                if ($urandom_range(0, 59) == 0) rx_calm <= $urandom_range(30, 60);
            end
        end
    end

    initial begin
        int         r;
        int         stop_at;
        line_flaw_t flaw;
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_line();

        // directed lines: each status, line controls, key wrap and the length cut
        queue_line(FL_NONE, 3);
        queue_line(FL_NONE, 17);
        queue_line(FL_NONE, 0);
        queue_line(FL_PREFIX, 2);
        queue_line(FL_SHORT, 0);
        queue_line(FL_NO_SEP, 3);
        queue_line(FL_CSUM_SHORT, 2);
        queue_line(FL_CSUM_NONHEX, 2);
        queue_line(FL_ODD, 2);
        queue_line(FL_PAY_NONHEX, 3);
        queue_line(FL_EXTRA_COLON, 2);
        queue_line(FL_MISMATCH, 4);
        queue_line(FL_TRAILING, 2);
        queue_line(FL_CR, 2);
        queue_line(FL_NUL, 2);
        queue_line(FL_NONE, 62);
        queue_line(FL_ODD, 59);
        rx_bytes.push_back(CH_NEWLINE);
        rx_bytes.push_back(8'hFF);
        rx_bytes.push_back(CH_NUL);
        rx_bytes.push_back(CH_NEWLINE);
        lines_built += 2;

        // random lines, mostly well formed
        stop_at = rx_bytes.size() + RANDOM_BYTES;
        while (rx_bytes.size() < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                queue_line(FL_NONE, $urandom_range(1, 8));
            end else if (r < 57) begin
                queue_line(FL_NONE, $urandom_range(20, 62));
            end else if (r < 90) begin
                flaw = line_flaw_t'($urandom_range(FL_PREFIX, FL_NUL));
                queue_line(flaw, $urandom_range(0, 8));
            end else begin
                queue_line(FL_NOISE, 0);
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (rx_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (decoded_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d bytes in %0d lines, %0d decoded bytes and %0d line results checked",
                 bytes_taken, lines_built, data_seen,
                 status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3]
                 + status_seen[4] + status_seen[5] + status_seen[6]);
        $display("line results by status 0..6: %0d %0d %0d %0d %0d %0d %0d, %0d mismatches",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], mismatches);
        if (mismatches == 0 && decoded_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
